// ===== rtl/rpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants for the rgb pixel blend unit.
// ----------------------------------------------------------------------------
package rpb_pkg;

  typedef logic [7:0] chan_t;
  typedef logic signed [8:0] ofs_t;
  typedef logic [1:0] cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_SUB     = 3'd1,
    MODE_MUL     = 3'd2,
    MODE_SCREEN  = 3'd3,
    MODE_OVERLAY = 3'd4,
    MODE_OFFSET  = 3'd5
  } blend_mode_t;

  localparam cfg_idx_t REG_MODE      = 2'd0;
  localparam cfg_idx_t REG_BLUE_OFS  = 2'd1;
  localparam cfg_idx_t REG_GREEN_OFS = 2'd2;
  localparam cfg_idx_t REG_RED_OFS   = 2'd3;

  localparam chan_t CHAN_MAX = 8'd255;

  // most negative 9-bit code, saturated to -CHAN_MAX on write
  localparam ofs_t OFS_MOST_NEG = 9'sh100;
  localparam ofs_t OFS_MIN      = -9'sd255;

  // floor(m/255) = (m * RECIP_MULT) >> RECIP_SHIFT for m below 132626
  localparam int unsigned PROD_W      = 17;
  localparam int unsigned QUOT_W      = 18;
  localparam logic [17:0] RECIP_MULT  = 18'd131587;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam logic [17:0] ROUND_BIAS  = 18'd127;

  // configuration seen by one channel's datapath
  typedef struct packed {
    blend_mode_t mode;
    ofs_t        ofs;
  } chan_cfg_t;

endpackage

// ===== rtl/rpb_if.sv =====
// ----------------------------------------------------------------------------
// rpb_if
// Handshake channels of the rgb pixel blend unit: pixel pair in, blended
// pixel out, register writes.
// ----------------------------------------------------------------------------
interface rpb_in_if import rpb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t top_blue;
  chan_t top_green;
  chan_t top_red;
  chan_t bottom_blue;
  chan_t bottom_green;
  chan_t bottom_red;

  modport source (
    output valid, top_blue, top_green, top_red,
           bottom_blue, bottom_green, bottom_red,
    input  ready
  );
  modport sink (
    input  valid, top_blue, top_green, top_red,
           bottom_blue, bottom_green, bottom_red,
    output ready
  );
endinterface

interface rpb_out_if import rpb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t out_blue;
  chan_t out_green;
  chan_t out_red;

  modport source (output valid, out_blue, out_green, out_red, input ready);
  modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface

interface rpb_cfg_if import rpb_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_idx_t   index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rpb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rpb_cfg_regs
// Mode and per-channel offset registers, with offset saturation on write.
// ----------------------------------------------------------------------------
module rpb_cfg_regs import rpb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  cfg_idx_t    wr_idx,
  input  logic [8:0]  wr_data,
  output blend_mode_t mode,
  output ofs_t        blue_ofs,
  output ofs_t        green_ofs,
  output ofs_t        red_ofs
);

  blend_mode_t mode_r;
  ofs_t        blue_ofs_r, green_ofs_r, red_ofs_r;
  ofs_t        ofs_sat;

  assign ofs_sat = (ofs_t'(wr_data) == OFS_MOST_NEG) ? OFS_MIN : ofs_t'(wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ADD;
      blue_ofs_r  <= '0;
      green_ofs_r <= '0;
      red_ofs_r   <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_MODE:      mode_r      <= blend_mode_t'(wr_data[2:0]);
        REG_BLUE_OFS:  blue_ofs_r  <= ofs_sat;
        REG_GREEN_OFS: green_ofs_r <= ofs_sat;
        REG_RED_OFS:   red_ofs_r   <= ofs_sat;
        default: ;
      endcase
    end
  end

  assign mode      = mode_r;
  assign blue_ofs  = blue_ofs_r;
  assign green_ofs = green_ofs_r;
  assign red_ofs   = red_ofs_r;

endmodule

// ===== rtl/rpb_chan_pipe.sv =====
// ----------------------------------------------------------------------------
// rpb_chan_pipe
// Four-stage datapath of one colour channel: operand prep, product,
// rounded divide by 255, invert and select.
// ----------------------------------------------------------------------------
module rpb_chan_pipe import rpb_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  chan_cfg_t cfg,
  input  chan_t     a,
  input  chan_t     b,
  output chan_t     res
);

  // stage 1: operands and the simple modes
  chan_t x_r, x_nxt, y_r, y_nxt;
  logic  dbl_r, dbl_nxt;
  logic  inv1_r, inv1_nxt;
  logic  dir1_r, dir1_nxt;
  chan_t val1_r, val1_nxt;

  logic [8:0]        sum;
  logic signed [9:0] ofs_sum;

  assign sum     = {1'b0, a} + {1'b0, b};
  assign ofs_sum = $signed({2'b00, a}) + $signed({cfg.ofs[8], cfg.ofs});

  always_comb begin
    x_nxt    = a;
    y_nxt    = b;
    dbl_nxt  = 1'b0;
    inv1_nxt = 1'b0;
    dir1_nxt = 1'b1;
    val1_nxt = a;
    case (cfg.mode)
      MODE_ADD: begin
        val1_nxt = sum[8] ? CHAN_MAX : sum[7:0];
      end
      MODE_SUB: begin
        val1_nxt = (a > b) ? (a - b) : '0;
      end
      MODE_MUL: begin
        dir1_nxt = 1'b0;
      end
      MODE_SCREEN: begin
        dir1_nxt = 1'b0;
        inv1_nxt = 1'b1;
        x_nxt    = CHAN_MAX - a;
        y_nxt    = CHAN_MAX - b;
      end
      MODE_OVERLAY: begin
        dir1_nxt = 1'b0;
        dbl_nxt  = 1'b1;
        // upper half of b takes the screen-like branch
        if (b[7]) begin
          inv1_nxt = 1'b1;
          x_nxt    = CHAN_MAX - a;
          y_nxt    = CHAN_MAX - b;
        end
      end
      MODE_OFFSET: begin
        if (ofs_sum[9]) begin
          val1_nxt = '0;
        end else if (ofs_sum[8]) begin
          val1_nxt = CHAN_MAX;
        end else begin
          val1_nxt = ofs_sum[7:0];
        end
      end
      default: ;
    endcase
  end

  // stage 2: product, doubled for overlay
  logic [PROD_W-1:0] n_r, n_nxt;
  logic              inv2_r, dir2_r;
  chan_t             val2_r;
  logic [15:0]       prod;

  assign prod  = x_r * y_r;
  assign n_nxt = dbl_r ? {prod, 1'b0} : {1'b0, prod};

  // stage 3: round(n/255) as floor((n+127)/255) by reciprocal multiply
  chan_t                     q_r, q_nxt;
  logic                      inv3_r, dir3_r;
  chan_t                     val3_r;
  logic [QUOT_W-1:0]         m;
  logic [2*QUOT_W-1:0]       qprod;

  assign m     = {{(QUOT_W-PROD_W){1'b0}}, n_r} + ROUND_BIAS;
  assign qprod = {{QUOT_W{1'b0}}, m} * {{QUOT_W{1'b0}}, RECIP_MULT};
  assign q_nxt = qprod[RECIP_SHIFT +: 8];

  // stage 4: result register
  chan_t res_r, res_nxt;

  always_comb begin
    if (dir3_r) begin
      res_nxt = val3_r;
    end else if (inv3_r) begin
      res_nxt = CHAN_MAX - q_r;
    end else begin
      res_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      dbl_r  <= dbl_nxt;
      inv1_r <= inv1_nxt;
      dir1_r <= dir1_nxt;
      val1_r <= val1_nxt;

      n_r    <= n_nxt;
      inv2_r <= inv1_r;
      dir2_r <= dir1_r;
      val2_r <= val1_r;

      q_r    <= q_nxt;
      inv3_r <= inv2_r;
      dir3_r <= dir2_r;
      val3_r <= val2_r;

      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/rgb_pixel_blend_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Per-channel blend of two BGR pixels with add, subtract, multiply, screen,
// overlay and offset modes.
// ----------------------------------------------------------------------------
// One pixel pair is taken per clock unless the output stalls; the four register
// stages (operand prep, 8x8 product, reciprocal multiply for the divide by 255,
// invert/select into the output register) all move together, so a stall at the
// output holds every stage and in_ch.ready drops only while the output register
// is full and not being taken. Register writes on cfg_ch are always accepted
// and must only be made while the pipeline is empty.
module rgb_pixel_blend_unit import rpb_pkg::*; (
  input logic clk,
  input logic rst_n,
  rpb_in_if.sink    in_ch,
  rpb_out_if.source out_ch,
  rpb_cfg_if.sink   cfg_ch
);

  localparam int unsigned STAGES = 4;

  blend_mode_t mode;
  ofs_t        blue_ofs, green_ofs, red_ofs;
  chan_cfg_t   blue_cfg, green_cfg, red_cfg;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic              advance;

  assign cfg_ch.ready = 1'b1;

  rpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_ch.valid),
    .wr_idx    (cfg_ch.index),
    .wr_data   (cfg_ch.data),
    .mode      (mode),
    .blue_ofs  (blue_ofs),
    .green_ofs (green_ofs),
    .red_ofs   (red_ofs)
  );

  assign blue_cfg  = '{mode: mode, ofs: blue_ofs};
  assign green_cfg = '{mode: mode, ofs: green_ofs};
  assign red_cfg   = '{mode: mode, ofs: red_ofs};

  // whole pipeline moves unless the output holds an untaken pixel
  assign advance     = !vld_r[STAGES-1] || out_ch.ready;
  assign in_ch.ready = advance;
  assign vld_nxt     = {vld_r[STAGES-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= vld_nxt;
    end
  end

  rpb_chan_pipe u_blue (
    .clk (clk),
    .en  (advance),
    .cfg (blue_cfg),
    .a   (in_ch.top_blue),
    .b   (in_ch.bottom_blue),
    .res (out_ch.out_blue)
  );

  rpb_chan_pipe u_green (
    .clk (clk),
    .en  (advance),
    .cfg (green_cfg),
    .a   (in_ch.top_green),
    .b   (in_ch.bottom_green),
    .res (out_ch.out_green)
  );

  rpb_chan_pipe u_red (
    .clk (clk),
    .en  (advance),
    .cfg (red_cfg),
    .a   (in_ch.top_red),
    .b   (in_ch.bottom_red),
    .res (out_ch.out_red)
  );

  assign out_ch.valid = vld_r[STAGES-1];

  // an accepted request always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  // a held output blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // nothing is dropped between the last two stages
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STAGES-2] && advance |=> out_ch.valid)
    else $error("pipeline item lost before output");

  // a stalled pipeline keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(vld_r))
    else $error("valid bits moved during stall");

endmodule
